### sv/imu_pkg.sv
package imu_pkg;

   // Field widths of the channels and the register port.
   localparam int SITE_W       = 8;
   localparam int RANDOM_W     = 64;
   localparam int MATCH_W      = 3;
   localparam int ENERGY_OUT_W = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 64;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  threshold_type;

   // Register indexes.
   localparam csr_index_type CSR_THRESHOLD_THREE = 2'd0;
   localparam csr_index_type CSR_THRESHOLD_FOUR  = 2'd1;

   // Acceptance thresholds as 0.64 fractions, about exp(-4jc) and exp(-8jc).
   localparam threshold_type THRESHOLD_THREE_RESET = 64'd3164960919797523686;
   localparam threshold_type THRESHOLD_FOUR_RESET  = 64'd543021444345275313;

endpackage

### sv/imu_req_if.sv
interface imu_req_if;
   logic                          valid;
   logic                          ready;
   logic [imu_pkg::SITE_W-1:0]    site_index;
   logic [imu_pkg::RANDOM_W-1:0]  random_word;

   modport source (output valid, site_index, random_word, input ready);
   modport sink   (input valid, site_index, random_word, output ready);
endinterface

### sv/imu_rsp_if.sv
interface imu_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    flipped;
   logic                                    new_spin;
   logic [imu_pkg::MATCH_W-1:0]             matching_neighbours;
   logic signed [imu_pkg::ENERGY_OUT_W-1:0] lattice_energy;

   modport source (output valid, flipped, new_spin, matching_neighbours, lattice_energy,
                   input ready);
   modport sink   (input valid, flipped, new_spin, matching_neighbours, lattice_energy,
                   output ready);
endinterface

### sv/ising_metropolis_update_unit.sv
// Single-site Metropolis update of a square Ising lattice with wrapped edges.
// A word on req_ch names a site (reduced modulo the site count) and carries a
// 64-bit random value. For each word exactly one word leaves on rsp_ch: whether
// the spin flipped, the new spin, how many of the four neighbors matched the
// old spin, and the running bond energy after the step.
// The user writes the two acceptance thresholds on the csr_ port only while the
// block is idle (not enforced); register 0 is for three matches, register 1 for four.
// The lattice is held one row per word in a row RAM. On acceptance the center
// and upper rows are read together, then the lower row, then the decision is
// made and the row written back if the spin flips. The next word is taken only
// after that, so no word is accepted before the last one is decided. The
// response is registered after the decision.
// The response sits in an output register. While rsp_ch is stalled, one more
// word can be accepted and read; it then waits in its decision cycle until the
// output register is free.
// Reset is synchronous. After reset the RAM is filled with +1 spins, one row
// per cycle, and req_ch stays not ready until every row is written. Thresholds
// and energy return to their reset values at once.
module ising_metropolis_update_unit #(
   parameter int LATTICE_SIDE = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [imu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [imu_pkg::CSR_DATA_W-1:0]     csr_write_data,
   imu_req_if.sink                            req_ch,
   imu_rsp_if.source                          rsp_ch
);

   localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
   localparam int ROW_W        = $clog2(LATTICE_SIDE);
   localparam int ENERGY_RAW_W = $clog2(2 * SITE_COUNT + 1) + 1;
   localparam int ENERGY_W     = (ENERGY_RAW_W > imu_pkg::ENERGY_OUT_W) ?
                                 ENERGY_RAW_W : imu_pkg::ENERGY_OUT_W;
   localparam int SITE_TABLE   = 1 << imu_pkg::SITE_W;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LATTICE_SIDE - 1);
   localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(2 * SITE_COUNT);

   localparam logic [1:0] ST_CLEAR      = 2'd0;
   localparam logic [1:0] ST_IDLE       = 2'd1;
   localparam logic [1:0] ST_FETCH_DOWN = 2'd2;
   localparam logic [1:0] ST_DECIDE     = 2'd3;

   function automatic logic [ROW_W-1:0] wrap_next(input logic [ROW_W-1:0] v);
      return (v == LAST_ROW) ? '0 : ROW_W'(v + 1'b1);
   endfunction

   function automatic logic [ROW_W-1:0] wrap_prev(input logic [ROW_W-1:0] v);
      return (v == '0) ? LAST_ROW : ROW_W'(v - 1'b1);
   endfunction

   logic [1:0]                        state_ff, state_in;
   logic [ROW_W-1:0]                  clr_row_ff, clr_row_in;
   logic [ROW_W-1:0]                  row_ff, row_in;
   logic [ROW_W-1:0]                  col_ff, col_in;
   logic [imu_pkg::RANDOM_W-1:0]      rnd_ff, rnd_in;
   logic [LATTICE_SIDE-1:0]           center_ff, center_in;
   imu_pkg::threshold_type            thr_three_ff, thr_three_in;
   imu_pkg::threshold_type            thr_four_ff, thr_four_in;
   logic signed [ENERGY_W-1:0]        energy_ff, energy_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_flipped_ff, rsp_flipped_in;
   logic                              rsp_spin_ff, rsp_spin_in;
   logic [imu_pkg::MATCH_W-1:0]       rsp_match_ff, rsp_match_in;
   logic signed [imu_pkg::ENERGY_OUT_W-1:0] rsp_energy_ff, rsp_energy_in;

   // Site to row and column, worked out for every index at elaboration.
   logic [ROW_W-1:0] row_tab [SITE_TABLE];
   logic [ROW_W-1:0] col_tab [SITE_TABLE];
   for (genvar v = 0; v < SITE_TABLE; v++) begin : g_site_tab
      assign row_tab[v] = ROW_W'((v % SITE_COUNT) / LATTICE_SIDE);
      assign col_tab[v] = ROW_W'((v % SITE_COUNT) % LATTICE_SIDE);
   end

   logic                        accept;
   logic                        adv;
   logic [ROW_W-1:0]            site_row;
   logic [ROW_W-1:0]            site_col;
   logic                        ram_wr_en;
   logic [ROW_W-1:0]            ram_wr_addr;
   logic [LATTICE_SIDE-1:0]     ram_wr_data;
   logic                        ram_rd_a_en;
   logic [ROW_W-1:0]            ram_rd_a_addr;
   logic [LATTICE_SIDE-1:0]     ram_rd_a_data;
   logic                        ram_rd_b_en;
   logic [ROW_W-1:0]            ram_rd_b_addr;
   logic [LATTICE_SIDE-1:0]     ram_rd_b_data;
   logic                        old_spin;
   logic                        nb_right, nb_left, nb_down, nb_up;
   logic [imu_pkg::MATCH_W-1:0] match_count;
   logic                        flip;
   logic signed [ENERGY_W-1:0]  energy_step;
   logic [LATTICE_SIDE-1:0]     flip_mask;
   logic [LATTICE_SIDE-1:0]     new_row;

   assign accept   = req_ch.valid && req_ch.ready;
   assign adv      = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ch.ready);
   assign site_row = row_tab[req_ch.site_index];
   assign site_col = col_tab[req_ch.site_index];

   assign req_ch.ready = (state_ff == ST_IDLE);

   // In the decision cycle port A holds the lower row and port B the upper row.
   assign old_spin = center_ff[col_ff];
   assign nb_right = center_ff[wrap_next(col_ff)];
   assign nb_left  = center_ff[wrap_prev(col_ff)];
   assign nb_down  = ram_rd_a_data[col_ff];
   assign nb_up    = ram_rd_b_data[col_ff];

   assign match_count = imu_pkg::MATCH_W'({2'b00, nb_right == old_spin})
                      + imu_pkg::MATCH_W'({2'b00, nb_left  == old_spin})
                      + imu_pkg::MATCH_W'({2'b00, nb_down  == old_spin})
                      + imu_pkg::MATCH_W'({2'b00, nb_up    == old_spin});

   always_comb begin
      priority if (match_count <= 3'd2) begin
         flip = 1'b1;
      end else if (match_count == 3'd3) begin
         flip = thr_three_ff > rnd_ff;
      end else begin
         flip = thr_four_ff > rnd_ff;
      end
   end

   always_comb begin
      unique case (match_count)
         3'd0:    energy_step = ENERGY_W'(8);
         3'd1:    energy_step = ENERGY_W'(4);
         3'd3:    energy_step = ENERGY_W'(-4);
         3'd4:    energy_step = ENERGY_W'(-8);
         default: energy_step = '0;
      endcase
   end

   assign flip_mask = LATTICE_SIDE'(flip) << col_ff;
   assign new_row   = center_ff ^ flip_mask;

   assign ram_wr_en     = (state_ff == ST_CLEAR) || (adv && flip);
   assign ram_wr_addr   = (state_ff == ST_CLEAR) ? clr_row_ff : row_ff;
   assign ram_wr_data   = (state_ff == ST_CLEAR) ? '1 : new_row;
   assign ram_rd_a_en   = accept || (state_ff == ST_FETCH_DOWN);
   assign ram_rd_a_addr = accept ? site_row : wrap_next(row_ff);
   assign ram_rd_b_en   = accept;
   assign ram_rd_b_addr = wrap_prev(site_row);

   imu_row_ram #(
      .WIDTH  (LATTICE_SIDE),
      .DEPTH  (LATTICE_SIDE),
      .ADDR_W (ROW_W)
   ) u_row_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_a_en   (ram_rd_a_en),
      .rd_a_addr (ram_rd_a_addr),
      .rd_a_data (ram_rd_a_data),
      .rd_b_en   (ram_rd_b_en),
      .rd_b_addr (ram_rd_b_addr),
      .rd_b_data (ram_rd_b_data)
   );

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rnd_in       = rnd_ff;
      center_in    = center_ff;
      thr_three_in = thr_three_ff;
      thr_four_in  = thr_four_ff;
      energy_in    = energy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_flipped_in = rsp_flipped_ff;
      rsp_spin_in    = rsp_spin_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_energy_in  = rsp_energy_ff;

      if (csr_write_enable && csr_index == imu_pkg::CSR_THRESHOLD_THREE) begin
         thr_three_in = csr_write_data;
      end
      if (csr_write_enable && csr_index == imu_pkg::CSR_THRESHOLD_FOUR) begin
         thr_four_in = csr_write_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_row_in = ROW_W'(clr_row_ff + 1'b1);
            if (clr_row_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               row_in   = site_row;
               col_in   = site_col;
               rnd_in   = req_ch.random_word;
               state_in = ST_FETCH_DOWN;
            end
         end
         ST_FETCH_DOWN: begin
            center_in = ram_rd_a_data;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (adv) begin
               if (flip) begin
                  energy_in = energy_ff + energy_step;
               end
               rsp_valid_in   = 1'b1;
               rsp_flipped_in = flip;
               rsp_spin_in    = old_spin ^ flip;
               rsp_match_in   = match_count;
               rsp_energy_in  = flip ? imu_pkg::ENERGY_OUT_W'(energy_ff + energy_step)
                                     : imu_pkg::ENERGY_OUT_W'(energy_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         thr_three_ff <= imu_pkg::THRESHOLD_THREE_RESET;
         thr_four_ff  <= imu_pkg::THRESHOLD_FOUR_RESET;
         energy_ff    <= ENERGY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         thr_three_ff <= thr_three_in;
         thr_four_ff  <= thr_four_in;
         energy_ff    <= energy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      col_ff         <= col_in;
      rnd_ff         <= rnd_in;
      center_ff      <= center_in;
      rsp_flipped_ff <= rsp_flipped_in;
      rsp_spin_ff    <= rsp_spin_in;
      rsp_match_ff   <= rsp_match_in;
      rsp_energy_ff  <= rsp_energy_in;
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.flipped             = rsp_flipped_ff;
   assign rsp_ch.new_spin            = rsp_spin_ff;
   assign rsp_ch.matching_neighbours = rsp_match_ff;
   assign rsp_ch.lattice_energy      = rsp_energy_ff;

   // The energy moves only in a decision cycle that hands off a response.
   a_energy_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(energy_ff))
      else $error("bond energy changed outside a completed update");

   // Every change of the energy is a multiple of four away from its reset value.
   a_energy_parity: assert property (@(posedge clock) disable iff (reset)
      energy_ff[1:0] == ENERGY_RESET[1:0])
      else $error("bond energy lost its parity");

   // A write-back changes at most the one spin of the updated site.
   a_single_spin_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && ram_wr_en) |-> $countones(ram_wr_data ^ center_ff) <= 1)
      else $error("row write-back changed more than one spin");

endmodule

### sv/imu_row_ram.sv
module imu_row_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_a_en,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [WIDTH-1:0]  rd_a_data,
   input  logic              rd_b_en,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds while its port is not enabled.
   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_data_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

### test/imu_update_checker.sv
`timescale 1ns / 100ps

module imu_update_checker #(
   parameter int LATTICE_SIDE = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  imu_pkg::csr_index_type csr_index,
   input  imu_pkg::threshold_type csr_write_data,
   imu_req_if                     req_mon,
   imu_rsp_if                     rsp_mon,
   output int                     mismatch_count,
   output int                     pending_words
);

   localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;

   typedef struct packed {
      logic                                    flipped;
      logic                                    new_spin;
      logic [imu_pkg::MATCH_W-1:0]             match_count;
      logic signed [imu_pkg::ENERGY_OUT_W-1:0] energy;
   } update_word_type;

   logic                   spins [SITE_COUNT];
   imu_pkg::threshold_type thr_three;
   imu_pkg::threshold_type thr_four;
   int                     energy;
   int                     fault_count = 0;
   update_word_type        expected_words [$];
   update_word_type        got;
   update_word_type        want;

   assign mismatch_count = fault_count;

   // Applies one Metropolis step to the local copy of the lattice and returns
   // the word the block should answer with.
   function automatic update_word_type apply_update(
         input logic [imu_pkg::SITE_W-1:0] site_in,
         input imu_pkg::threshold_type     rnd);
      int              site;
      int              row;
      int              col;
      int              match_count;
      int              nb [4];
      logic            old_spin;
      logic            flip;
      update_word_type w;
      site  = int'(site_in) % SITE_COUNT;
      row   = site / LATTICE_SIDE;
      col   = site % LATTICE_SIDE;
      nb[0] = row * LATTICE_SIDE + (col + 1) % LATTICE_SIDE;
      nb[1] = row * LATTICE_SIDE + (col + LATTICE_SIDE - 1) % LATTICE_SIDE;
      nb[2] = ((row + 1) % LATTICE_SIDE) * LATTICE_SIDE + col;
      nb[3] = ((row + LATTICE_SIDE - 1) % LATTICE_SIDE) * LATTICE_SIDE + col;
      old_spin    = spins[site];
      match_count = 0;
      foreach (nb[k]) begin
         if (spins[nb[k]] == old_spin) match_count++;
      end
      if (match_count <= 2) flip = 1'b1;
      else if (match_count == 3) flip = thr_three > rnd;
      else flip = thr_four > rnd;
      if (flip) begin
         spins[site] = ~old_spin;
         energy += 8 - 4 * match_count;
      end
      w.flipped     = flip;
      w.new_spin    = spins[site];
      w.match_count = match_count[imu_pkg::MATCH_W-1:0];
      w.energy      = energy[imu_pkg::ENERGY_OUT_W-1:0];
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (spins[k]) spins[k] = 1'b1;
         thr_three = imu_pkg::THRESHOLD_THREE_RESET;
         thr_four  = imu_pkg::THRESHOLD_FOUR_RESET;
         energy    = 2 * SITE_COUNT;
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               imu_pkg::CSR_THRESHOLD_THREE: thr_three = csr_write_data;
               imu_pkg::CSR_THRESHOLD_FOUR:  thr_four  = csr_write_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(apply_update(req_mon.site_index, req_mon.random_word));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.flipped     = rsp_mon.flipped;
            got.new_spin    = rsp_mon.new_spin;
            got.match_count = rsp_mon.matching_neighbours;
            got.energy      = rsp_mon.lattice_energy;
            if (expected_words.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected update word: flipped=%0d spin=%0d matches=%0d energy=%0d",
                           got.flipped, got.new_spin, got.match_count, got.energy);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"update word mismatch: expected flipped=%0d spin=%0d ",
                               "matches=%0d energy=%0d, got flipped=%0d spin=%0d ",
                               "matches=%0d energy=%0d"},
                              want.flipped, want.new_spin, want.match_count, want.energy,
                              got.flipped, got.new_spin, got.match_count, got.energy);
               end
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int                     LATTICE_SIDE = 16;
   localparam int                     SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
   localparam int                     CYCLE_LIMIT  = 400000;
   localparam imu_pkg::threshold_type ALL_ONES     = '1;
   // Indexes the port can address but that hold no register.
   localparam imu_pkg::csr_index_type CSR_SPARE_LOW  = 2'd2;
   localparam imu_pkg::csr_index_type CSR_SPARE_HIGH = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   imu_pkg::csr_index_type csr_index;
   imu_pkg::threshold_type csr_write_data;
   int                     send_gap_pct;
   int                     stall_pct;
   int                     cycle_count = 0;
   int                     mismatch_count;
   int                     pending_words;
   int                     focus_site;
   imu_pkg::threshold_type cur_three;
   imu_pkg::threshold_type cur_four;

   imu_req_if req_ch ();
   imu_rsp_if rsp_ch ();

   ising_metropolis_update_unit #(
      .LATTICE_SIDE (LATTICE_SIDE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   imu_update_checker #(
      .LATTICE_SIDE (LATTICE_SIDE)
   ) update_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .mismatch_count   (mismatch_count),
      .pending_words    (pending_words)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Leaves valid high after the handshake, so back-to-back words need no
   // second assignment to valid in the same step.
   task automatic send_word(input logic [imu_pkg::SITE_W-1:0] site,
                            input imu_pkg::threshold_type word);
      if ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.site_index  <= site;
      req_ch.random_word <= word;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // The pending count is registered and lags; the tail covers the last update.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_thresholds(input imu_pkg::threshold_type three,
                                 input imu_pkg::threshold_type four);
      csr_write_enable <= 1'b1;
      csr_index        <= imu_pkg::CSR_THRESHOLD_THREE;
      csr_write_data   <= three;
      @(posedge clock);
      csr_index        <= imu_pkg::CSR_THRESHOLD_FOUR;
      csr_write_data   <= four;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_three = three;
      cur_four  = four;
   endtask

   // Part of the sites cluster around a moving focus so that neighborhoods
   // evolve together; words often sit right at a threshold.
   task automatic run_phase(input int count, input bit pause_midway);
      int                     row;
      int                     col;
      logic [7:0]             site;
      imu_pkg::threshold_type word;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 35) begin
            row  = (focus_site / LATTICE_SIDE + LATTICE_SIDE - 1 + $urandom_range(2))
                   % LATTICE_SIDE;
            col  = (focus_site % LATTICE_SIDE + LATTICE_SIDE - 1 + $urandom_range(2))
                   % LATTICE_SIDE;
            site = 8'(row * LATTICE_SIDE + col);
         end else begin
            site = 8'($urandom_range(SITE_COUNT - 1));
            if ($urandom_range(9) == 0) focus_site = site;
         end
         case ($urandom_range(9))
            0, 1, 2, 3: word = {$urandom(), $urandom()};
            4:          word = cur_three + imu_pkg::threshold_type'($urandom_range(2))
                               - 64'd1;
            5:          word = cur_four + imu_pkg::threshold_type'($urandom_range(2))
                               - 64'd1;
            6:          word = '0;
            7:          word = ALL_ONES;
            default:    word = imu_pkg::threshold_type'($urandom()) << $urandom_range(63);
         endcase
         send_word(site, word);
         if (pause_midway && i == count / 2) wait_drained();
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = imu_pkg::CSR_THRESHOLD_THREE;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.site_index  = '0;
      req_ch.random_word = '0;
      send_gap_pct       = 0;
      stall_pct          = 0;
      focus_site         = 0;
      cur_three          = imu_pkg::THRESHOLD_THREE_RESET;
      cur_four           = imu_pkg::THRESHOLD_FOUR_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Build a small pattern by hand so that every neighbor count from four
      // down to zero shows up, with words on both sides of each threshold.
      send_word(8'd17, '0);
      send_word(8'd16, '0);
      send_word(8'd18, '0);
      send_word(8'd1, '0);
      send_word(8'd33, '0);
      send_word(8'd17, ALL_ONES);
      send_word(8'd17, '0);
      send_word(8'd17, ALL_ONES);
      send_word(8'd0, ALL_ONES);
      send_word(8'd255, ALL_ONES);
      send_word(8'd255, '0);
      send_word(8'd128, imu_pkg::THRESHOLD_FOUR_RESET);
      send_word(8'd128, imu_pkg::THRESHOLD_FOUR_RESET - 64'd1);
      send_word(8'd129, imu_pkg::THRESHOLD_THREE_RESET);
      send_word(8'd129, imu_pkg::THRESHOLD_THREE_RESET - 64'd1);
      send_word(8'd128, ALL_ONES);
      wait_drained();
      set_thresholds('0, '0);
      send_word(8'd200, '0);
      send_word(8'd130, '0);
      wait_drained();
      set_thresholds(ALL_ONES, ALL_ONES);
      send_word(8'd200, ALL_ONES);
      send_word(8'd200, ALL_ONES - 64'd1);
      send_word(8'd130, ALL_ONES);
      send_word(8'd130, ALL_ONES - 64'd1);
      wait_drained();
      // Writes to unused indexes must leave both thresholds alone.
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SPARE_LOW;
      csr_write_data   <= '0;
      @(posedge clock);
      csr_index        <= CSR_SPARE_HIGH;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      send_word(8'd201, ALL_ONES - 64'd1);
      wait_drained();

      set_thresholds(imu_pkg::THRESHOLD_THREE_RESET, imu_pkg::THRESHOLD_FOUR_RESET);
      send_gap_pct = 20;
      stall_pct    = 56;
      run_phase(360, 1'b1);
      wait_drained();

      set_thresholds({$urandom(), $urandom()}, {$urandom(), $urandom()});
      send_gap_pct = 56;
      stall_pct    = 20;
      run_phase(360, 1'b0);
      wait_drained();

      set_thresholds({$urandom(), $urandom()}, {4'h0, 28'($urandom()), $urandom()});
      send_gap_pct = 0;
      stall_pct    = 0;
      run_phase(380, 1'b0);
      wait_drained();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
sv/imu_pkg.sv
sv/imu_req_if.sv
sv/imu_rsp_if.sv
sv/imu_row_ram.sv
sv/ising_metropolis_update_unit.sv
test/imu_update_checker.sv
test/tb_top.sv
